// File: rtl/tfun_pkg.sv
// Package for the triangle face unit normal core: widths and shared types.
// No dependencies; used by the core and tfun_pipe.
package tfun_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int OUT_WIDTH = 32;
    localparam int A_WIDTH   = 31;
    localparam int L_WIDTH   = 64;
    localparam int SQ_WIDTH  = 126;
    localparam int LEN_WIDTH = 63;
    localparam int Q_WIDTH   = 32;
    localparam logic [Q_WIDTH-1:0] ONE_Q30 = 32'h4000_0000;

    // Input word: three corners, signed Q16.16.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] corner0_x, corner0_y, corner0_z;
        logic signed [COORD_WIDTH-1:0] corner1_x, corner1_y, corner1_z;
        logic signed [COORD_WIDTH-1:0] corner2_x, corner2_y, corner2_z;
    } tfun_in_t;

    // Output word: unit normal in signed Q1.30 and the degenerate flag.
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normal_x, normal_y, normal_z;
        logic                        degenerate;
    } tfun_out_t;

    // Scaled magnitudes and signs for the three components.
    typedef struct packed {
        logic [A_WIDTH-1:0] ax;
        logic [A_WIDTH-1:0] ay;
        logic [A_WIDTH-1:0] az;
        logic               nx;
        logic               ny;
        logic               nz;
        logic               degen;
    } tfun_mag_t;

endpackage

// File: rtl/tfun_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing; used by the core.
interface tfun_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/triangle_face_unit_normal_core.sv
// Channel   Direction  Word
// in_ch     sink       nine corner coordinates, signed Q16.16
// out_ch    source     normal_x/y/z signed Q1.30, degenerate flag
//
// The core is one pipeline of enable-gated stages; a new word can enter in
// every cycle unless the output stalls. Stages: six arithmetic, 63 square
// root (one root bit each), 32 divider (one quotient bit each) and the
// output register. A stall freezes the whole pipeline, bubbles included,
// so a full output holds back the input. Reset clears valid bits only.
// Depends on tfun_pkg, tfun_if and tfun_pipe.
module triangle_face_unit_normal_core
    import tfun_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tfun_if.sink   in_ch,
    tfun_if.source out_ch
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int SW = (CW > 33) ? CW - 31 : 1;
    localparam int SQ_STEPS = LEN_WIDTH;
    localparam int DV_STEPS = Q_WIDTH;
    localparam int NUM_WIDTH = 95;
    localparam int DEN_WIDTH = LEN_WIDTH + 1;

    typedef struct packed {
        logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
    } edge_t;
    typedef struct packed {
        logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
    } prod_t;
    typedef struct packed {
        logic signed [CW-1:0] cx, cy, cz;
    } cross_t;
    typedef struct packed {
        tfun_mag_t            m;
        logic [L_WIDTH-1:0]   l;
    } len_t;
    // Square root state: remainder, partial root.
    typedef struct packed {
        tfun_mag_t              m;
        logic [SQ_WIDTH+1:0]    rem;
        logic [LEN_WIDTH-1:0]   root;
        logic [SQ_WIDTH-1:0]    src;
    } sq_t;
    // Divider state for three components.
    typedef struct packed {
        logic                   nx, ny, nz, degen;
        logic [DEN_WIDTH-1:0]   den;
        logic [NUM_WIDTH-1:0]   numx, numy, numz;
        logic [DEN_WIDTH:0]     rx, ry, rz;
        logic [Q_WIDTH-1:0]     qx, qy, qz;
    } dv_t;

    // Output register: pipeline advances unless output is full.
    logic en;
    logic out_valid_reg;
    logic [3*OUT_WIDTH:0] out_data_reg;
    logic [3*OUT_WIDTH:0] res_data;
    logic res_valid;
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: edge vectors.
    edge_t s1_d;
    logic signed [COORD_WIDTH-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
    assign c0x = in_ch.data.corner0_x[COORD_WIDTH-1:0];
    assign c0y = in_ch.data.corner0_y[COORD_WIDTH-1:0];
    assign c0z = in_ch.data.corner0_z[COORD_WIDTH-1:0];
    assign c1x = in_ch.data.corner1_x[COORD_WIDTH-1:0];
    assign c1y = in_ch.data.corner1_y[COORD_WIDTH-1:0];
    assign c1z = in_ch.data.corner1_z[COORD_WIDTH-1:0];
    assign c2x = in_ch.data.corner2_x[COORD_WIDTH-1:0];
    assign c2y = in_ch.data.corner2_y[COORD_WIDTH-1:0];
    assign c2z = in_ch.data.corner2_z[COORD_WIDTH-1:0];
    always_comb
    begin
        s1_d.e1x = EW'(c1x) - EW'(c0x);
        s1_d.e1y = EW'(c1y) - EW'(c0y);
        s1_d.e1z = EW'(c1z) - EW'(c0z);
        s1_d.e2x = EW'(c2x) - EW'(c0x);
        s1_d.e2y = EW'(c2y) - EW'(c0y);
        s1_d.e2z = EW'(c2z) - EW'(c0z);
    end
    logic  v1;
    edge_t q1;
    tfun_pipe #(.W($bits(edge_t))) u_s1 (.clk, .rst_n, .en,
        .in_valid(in_ch.valid), .in_data(s1_d), .out_valid(v1), .out_data(q1));

    // Stage 2: six products.
    prod_t s2_d;
    always_comb
    begin
        s2_d.p0 = PW'(q1.e1y) * PW'(q1.e2z);
        s2_d.p1 = PW'(q1.e1z) * PW'(q1.e2y);
        s2_d.p2 = PW'(q1.e1z) * PW'(q1.e2x);
        s2_d.p3 = PW'(q1.e1x) * PW'(q1.e2z);
        s2_d.p4 = PW'(q1.e1x) * PW'(q1.e2y);
        s2_d.p5 = PW'(q1.e1y) * PW'(q1.e2x);
    end
    logic  v2;
    prod_t q2;
    tfun_pipe #(.W($bits(prod_t))) u_s2 (.clk, .rst_n, .en,
        .in_valid(v1), .in_data(s2_d), .out_valid(v2), .out_data(q2));

    // Stage 3: cross product differences.
    cross_t s3_d;
    always_comb
    begin
        s3_d.cx = CW'(q2.p0) - CW'(q2.p1);
        s3_d.cy = CW'(q2.p2) - CW'(q2.p3);
        s3_d.cz = CW'(q2.p4) - CW'(q2.p5);
    end
    logic   v3;
    cross_t q3;
    tfun_pipe #(.W($bits(cross_t))) u_s3 (.clk, .rst_n, .en,
        .in_valid(v2), .in_data(s3_d), .out_valid(v3), .out_data(q3));

    // Stage 4: magnitudes, signs, bit length and scaling to 31 bits.
    tfun_mag_t s4_d;
    always_comb
    begin
        logic [CW-1:0] mx, my, mz, orv;
        logic [SW-1:0] s;
        mx = q3.cx[CW-1] ? CW'(-q3.cx) : CW'(q3.cx);
        my = q3.cy[CW-1] ? CW'(-q3.cy) : CW'(q3.cy);
        mz = q3.cz[CW-1] ? CW'(-q3.cz) : CW'(q3.cz);
        orv = mx | my | mz;
        s = '0;
        for (int b = 31; b < CW; b++)
        begin
            if (orv[b])
            begin
                s = SW'(b - 30);
            end
        end
        s4_d.ax = A_WIDTH'(mx >> s);
        s4_d.ay = A_WIDTH'(my >> s);
        s4_d.az = A_WIDTH'(mz >> s);
        s4_d.nx = q3.cx[CW-1];
        s4_d.ny = q3.cy[CW-1];
        s4_d.nz = q3.cz[CW-1];
        s4_d.degen = (orv == '0);
    end
    logic      v4;
    tfun_mag_t q4;
    tfun_pipe #(.W($bits(tfun_mag_t))) u_s4 (.clk, .rst_n, .en,
        .in_valid(v3), .in_data(s4_d), .out_valid(v4), .out_data(q4));

    // Stage 5: squares.
    typedef struct packed {
        tfun_mag_t m;
        logic [2*A_WIDTH-1:0] sx, sy, sz;
    } sqr_t;
    sqr_t s5_d, q5;
    logic v5;
    always_comb
    begin
        s5_d.m  = q4;
        s5_d.sx = (2*A_WIDTH)'(q4.ax) * (2*A_WIDTH)'(q4.ax);
        s5_d.sy = (2*A_WIDTH)'(q4.ay) * (2*A_WIDTH)'(q4.ay);
        s5_d.sz = (2*A_WIDTH)'(q4.az) * (2*A_WIDTH)'(q4.az);
    end
    tfun_pipe #(.W($bits(sqr_t))) u_s5 (.clk, .rst_n, .en,
        .in_valid(v4), .in_data(s5_d), .out_valid(v5), .out_data(q5));

    // Stage 6: sum of squares.
    len_t s6_d, q6;
    logic v6;
    always_comb
    begin
        s6_d.m = q5.m;
        s6_d.l = L_WIDTH'(q5.sx) + L_WIDTH'(q5.sy) + L_WIDTH'(q5.sz);
    end
    tfun_pipe #(.W($bits(len_t))) u_s6 (.clk, .rst_n, .en,
        .in_valid(v5), .in_data(s6_d), .out_valid(v6), .out_data(q6));

    // Square root of L * 2^62, one root bit per stage.
    sq_t  sq_q [SQ_STEPS+1];
    logic sq_v [SQ_STEPS+1];
    assign sq_v[0]      = v6;
    assign sq_q[0].m    = q6.m;
    assign sq_q[0].rem  = '0;
    assign sq_q[0].root = '0;
    assign sq_q[0].src  = {q6.l[SQ_WIDTH-63:0], 62'd0};
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        sq_t d;
        always_comb
        begin
            logic [SQ_WIDTH+1:0] r, t;
            r = {sq_q[k].rem[SQ_WIDTH-1:0], sq_q[k].src[SQ_WIDTH-1 -: 2]};
            t = (SQ_WIDTH+2)'({sq_q[k].root, 2'b01});
            d.m   = sq_q[k].m;
            d.src = {sq_q[k].src[SQ_WIDTH-3:0], 2'b00};
            if (r >= t)
            begin
                d.rem  = r - t;
                d.root = {sq_q[k].root[LEN_WIDTH-2:0], 1'b1};
            end
            else
            begin
                d.rem  = r;
                d.root = {sq_q[k].root[LEN_WIDTH-2:0], 1'b0};
            end
        end
        tfun_pipe #(.W($bits(sq_t))) u_st (.clk, .rst_n, .en,
            .in_valid(sq_v[k]), .in_data(d),
            .out_valid(sq_v[k+1]), .out_data(sq_q[k+1]));
    end

    // Divider set-up: numerator a*2^62 + len, divisor 2*len.
    dv_t  dv_q [DV_STEPS+1];
    logic dv_v [DV_STEPS+1];
    logic [LEN_WIDTH-1:0] len;
    tfun_mag_t mq;
    assign len = sq_q[SQ_STEPS].root;
    assign mq  = sq_q[SQ_STEPS].m;
    assign dv_v[0] = sq_v[SQ_STEPS];
    always_comb
    begin
        dv_q[0].nx = mq.nx;
        dv_q[0].ny = mq.ny;
        dv_q[0].nz = mq.nz;
        dv_q[0].degen = mq.degen;
        dv_q[0].den = {len, 1'b0};
        dv_q[0].numx = NUM_WIDTH'({mq.ax, 62'd0}) + NUM_WIDTH'(len);
        dv_q[0].numy = NUM_WIDTH'({mq.ay, 62'd0}) + NUM_WIDTH'(len);
        dv_q[0].numz = NUM_WIDTH'({mq.az, 62'd0}) + NUM_WIDTH'(len);
        dv_q[0].rx = '0;
        dv_q[0].ry = '0;
        dv_q[0].rz = '0;
        dv_q[0].qx = '0;
        dv_q[0].qy = '0;
        dv_q[0].qz = '0;
    end
    // The quotient is at most 2^31, so the top 63 numerator bits always
    // give a partial remainder below the divisor; they seed the remainder.
    function automatic logic [DEN_WIDTH:0] seed(input logic [NUM_WIDTH-1:0] n);
        return (DEN_WIDTH+1)'(n[NUM_WIDTH-1:Q_WIDTH]);
    endfunction
    for (genvar k = 0; k < DV_STEPS; k++)
    begin : g_div
        dv_t d;
        always_comb
        begin
            logic [DEN_WIDTH:0] rx, ry, rz, dd;
            logic [NUM_WIDTH-1:0] nxs, nys, nzs;
            d = dv_q[k];
            dd = (DEN_WIDTH+1)'(dv_q[k].den);
            if (k == 0)
            begin
                rx = seed(dv_q[k].numx);
                ry = seed(dv_q[k].numy);
                rz = seed(dv_q[k].numz);
            end
            else
            begin
                rx = dv_q[k].rx;
                ry = dv_q[k].ry;
                rz = dv_q[k].rz;
            end
            nxs = dv_q[k].numx;
            nys = dv_q[k].numy;
            nzs = dv_q[k].numz;
            rx = {rx[DEN_WIDTH-1:0], nxs[Q_WIDTH-1-k]};
            ry = {ry[DEN_WIDTH-1:0], nys[Q_WIDTH-1-k]};
            rz = {rz[DEN_WIDTH-1:0], nzs[Q_WIDTH-1-k]};
            d.qx = {dv_q[k].qx[Q_WIDTH-2:0], rx >= dd};
            d.qy = {dv_q[k].qy[Q_WIDTH-2:0], ry >= dd};
            d.qz = {dv_q[k].qz[Q_WIDTH-2:0], rz >= dd};
            d.rx = (rx >= dd) ? rx - dd : rx;
            d.ry = (ry >= dd) ? ry - dd : ry;
            d.rz = (rz >= dd) ? rz - dd : rz;
        end
        tfun_pipe #(.W($bits(dv_t))) u_dt (.clk, .rst_n, .en,
            .in_valid(dv_v[k]), .in_data(d),
            .out_valid(dv_v[k+1]), .out_data(dv_q[k+1]));
    end

    // Saturation, sign and degenerate zeroing.
    function automatic logic [OUT_WIDTH-1:0] fin(input logic [Q_WIDTH-1:0] q,
                                                 input logic n, input logic z);
        logic [Q_WIDTH-1:0] s;
        s = (q > ONE_Q30) ? ONE_Q30 : q;
        if (z)
        begin
            return '0;
        end
        return n ? OUT_WIDTH'(-s) : OUT_WIDTH'(s);
    endfunction
    dv_t dl;
    assign dl = dv_q[DV_STEPS];
    assign res_valid = dv_v[DV_STEPS];
    assign res_data = {fin(dl.qx, dl.nx, dl.degen), fin(dl.qy, dl.ny, dl.degen),
                       fin(dl.qz, dl.nz, dl.degen), dl.degen};

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= res_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_data;
        end
    end
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.data.normal_x  = out_data_reg[3*OUT_WIDTH -: OUT_WIDTH];
    assign out_ch.data.normal_y  = out_data_reg[2*OUT_WIDTH -: OUT_WIDTH];
    assign out_ch.data.normal_z  = out_data_reg[OUT_WIDTH -: OUT_WIDTH];
    assign out_ch.data.degenerate = out_data_reg[0];

`ifndef SYNTH
    // A stalled output word must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_data_reg))
        else $error("output word changed under stall");
    // A degenerate word carries a zero normal.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_data_reg[0] |-> out_data_reg[3*OUT_WIDTH:1] == '0)
        else $error("degenerate word with nonzero normal");
    // The pipeline accepts whenever the output is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty output");
`endif
endmodule

// File: rtl/tfun_pipe.sv
// One pipeline stage register bank with valid bit and stall control.
// Depends on tfun_pkg; instantiated by the top level.
module tfun_pipe
    import tfun_pkg::*;
#(
    parameter int W = 8
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    logic         valid_reg;
    logic [W-1:0] data_reg;

    // Valid travels with the data; the stage holds while disabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
